### src/mfu_pkg.sv
// Shared types and constants for the motor feedback unwrap block.
package mfu_pkg;

    localparam int MOTORS_DEFAULT = 8;
    localparam int ENCODER_COUNTS = 8192;

    localparam logic [10:0] FEEDBACK_FIRST = 11'h201;
    localparam logic [10:0] FEEDBACK_BASE  = 11'h200;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 80;

    typedef enum logic {
        KIND_FEEDBACK = 1'b0,
        KIND_RESET    = 1'b1
    } kind_t;

    typedef struct packed {
        logic [15:0]        angle;
        logic signed [31:0] position;
        logic [15:0]        speed;
        logic [15:0]        current;
        logic [7:0]         temp;
    } motor_rec_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] angle;
        logic [15:0] speed;
        logic [15:0] current;
        logic [7:0]  temp;
    } frame_t;

endpackage

### src/motor_feedback_unwrap_core.sv
// Top level: motor feedback decoder with per-motor multi-turn position memory.
// One item is accepted per clock when the result side keeps up; each item gives
// exactly one result, which passes through the update stage and the output
// register, and a stalled result side holds the update stage and with it the
// input. The per-motor state lives in a memory with a registered read, so the
// motor's record is read as the item is accepted, and the update stage then
// updates it, writes it back and loads the output register. A result written
// back in the same cycle that the next item reads that motor is forwarded, so
// consecutive frames for one motor need no bubble. Reset takes effect at once
// through one valid bit per motor; a motor never written reads as all zeros.
module motor_feedback_unwrap_core
#(
    parameter int MOTORS = mfu_pkg::MOTORS_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // can_id[10:0], payload[74:11], motor_index[77:75], zero[79:78]
    input  logic [mfu_pkg::IN_DATA_W-1:0]   s_tdata,
    // kind[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // motor_number[2:0], position_count[34:3], speed_rpm[50:35],
    // torque_current[66:51], temperature[74:67], zero[79:75]
    output logic [mfu_pkg::OUT_DATA_W-1:0]  m_tdata,
    // accepted[0]
    output logic                            m_tuser
);

    localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam logic [3:0]  MOTORS_4 = 4'(MOTORS);
    localparam logic [10:0] FEEDBACK_LAST = 11'(mfu_pkg::FEEDBACK_BASE + 11'(MOTORS));

    // input decode
    logic [10:0]        in_can_id;
    logic [63:0]        in_payload;
    logic [2:0]         in_motor_index;
    mfu_pkg::frame_t    in_frame;
    logic [10:0]        in_offset;
    logic               in_hit;
    logic [2:0]         in_motor;
    logic [IDX_W-1:0]   in_addr;
    logic               accept;

    // stage 1
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_hit_reg;
    logic [2:0]         s1_motor_reg;
    logic [IDX_W-1:0]   s1_addr_reg;
    mfu_pkg::frame_t    s1_frame_reg;
    logic               s1_advance;

    // memory and forwarding
    mfu_pkg::motor_rec_t state_mem [MOTORS];
    mfu_pkg::motor_rec_t rd_data_reg;
    logic                rd_valid_reg;
    logic [MOTORS-1:0]   valid_reg, valid_next;
    logic                fwd_hit_reg, fwd_hit_next;
    mfu_pkg::motor_rec_t fwd_data_reg;
    mfu_pkg::motor_rec_t cur_rec;
    mfu_pkg::motor_rec_t new_rec;
    logic                wr_en;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [mfu_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                          m_user_reg, m_user_next;

    assign in_can_id      = s_tdata[10:0];
    assign in_payload     = s_tdata[74:11];
    assign in_motor_index = s_tdata[77:75];

    always_comb
    begin
        in_frame.kind    = mfu_pkg::kind_t'(s_tuser);
        in_frame.angle   = in_payload[63:48];
        in_frame.speed   = in_payload[47:32];
        in_frame.current = in_payload[31:16];
        in_frame.temp    = in_payload[15:8];
        in_offset        = in_can_id - mfu_pkg::FEEDBACK_FIRST;
        case (in_frame.kind)
            mfu_pkg::KIND_RESET:
            begin
                in_hit   = ({1'b0, in_motor_index} < MOTORS_4);
                in_motor = in_motor_index;
            end
            mfu_pkg::KIND_FEEDBACK:
            begin
                in_hit   = (in_can_id >= mfu_pkg::FEEDBACK_FIRST) &&
                           (in_can_id <= FEEDBACK_LAST);
                in_motor = in_hit ? in_offset[2:0] : 3'd0;
            end
            default:
            begin
                in_hit   = 1'b0;
                in_motor = 3'd0;
            end
        endcase
        in_addr = in_motor[IDX_W-1:0];
    end

    assign s1_advance = !m_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign accept     = s_tvalid && s_tready;
    assign wr_en      = s1_valid_reg && s1_hit_reg && s1_advance;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[s1_addr_reg] = 1'b1;
        end
        // hold the forwarded record for as long as its item waits in stage 1
        if (accept)
        begin
            fwd_hit_next = wr_en && (s1_addr_reg == in_addr);
        end
        else if (s1_advance)
        begin
            fwd_hit_next = 1'b0;
        end
        else
        begin
            fwd_hit_next = fwd_hit_reg;
        end
    end

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur_rec = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            cur_rec = rd_data_reg;
        end
        else
        begin
            cur_rec = '0;
        end
    end

    mfu_update u_update
    (
        .frame   (s1_frame_reg),
        .rec_in  (cur_rec),
        .rec_out (new_rec)
    );

    always_comb
    begin
        if (s1_valid_reg && s1_advance)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
        m_user_next = s1_hit_reg;
        m_data_next = '0;
        m_data_next[2:0] = s1_motor_reg;
        if (s1_hit_reg)
        begin
            m_data_next[34:3]  = new_rec.position;
            m_data_next[50:35] = new_rec.speed;
            m_data_next[66:51] = new_rec.current;
            m_data_next[74:67] = new_rec.temp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            valid_reg    <= '0;
            fwd_hit_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            valid_reg    <= valid_next;
            fwd_hit_reg  <= fwd_hit_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hit_reg   <= in_hit;
            s1_motor_reg <= in_motor;
            s1_addr_reg  <= in_addr;
            s1_frame_reg <= in_frame;
            rd_data_reg  <= state_mem[in_addr];
            rd_valid_reg <= valid_reg[in_addr];
            fwd_data_reg <= new_rec;
        end
        if (wr_en)
        begin
            state_mem[s1_addr_reg] <= new_rec;
        end
        if (s1_valid_reg && s1_advance)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("forwarded record without an item in the update stage");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance) |=> m_tvalid)
        else $error("item left the update stage without a result");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[79:3] == '0))
        else $error("rejected item carries nonzero state fields");

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> (($past(valid_reg) & ~valid_reg) == '0))
        else $error("motor valid bit cleared outside reset");

endmodule

### src/mfu_update.sv
// Per-motor record update: angle unwrap, saturating position, field refresh; a reset frame clears only the position.
module mfu_update
(
    input  mfu_pkg::frame_t     frame,
    input  mfu_pkg::motor_rec_t rec_in,
    output mfu_pkg::motor_rec_t rec_out
);

    localparam logic signed [17:0] HALF   = 18'(mfu_pkg::ENCODER_COUNTS / 2);
    localparam logic signed [17:0] COUNTS = 18'(mfu_pkg::ENCODER_COUNTS);

    logic signed [17:0] diff;
    logic signed [17:0] delta;
    logic signed [33:0] sum;
    logic signed [31:0] sat;

    always_comb
    begin
        diff = $signed({2'b00, frame.angle}) - $signed({2'b00, rec_in.angle});
        if (diff < -HALF)
        begin
            delta = diff + COUNTS;
        end
        else if (diff > HALF)
        begin
            delta = diff - COUNTS;
        end
        else
        begin
            delta = diff;
        end
        sum = {{2{rec_in.position[31]}}, rec_in.position} + {{16{delta[17]}}, delta};
        if ((sum[33:31] == 3'b000) || (sum[33:31] == 3'b111))
        begin
            sat = sum[31:0];
        end
        else if (sum[33])
        begin
            sat = {1'b1, {31{1'b0}}};
        end
        else
        begin
            sat = {1'b0, {31{1'b1}}};
        end
    end

    always_comb
    begin
        rec_out = rec_in;
        case (frame.kind)
            mfu_pkg::KIND_RESET:
            begin
                rec_out.position = '0;
            end
            mfu_pkg::KIND_FEEDBACK:
            begin
                rec_out.angle    = frame.angle;
                rec_out.position = sat;
                rec_out.speed    = frame.speed;
                rec_out.current  = frame.current;
                rec_out.temp     = frame.temp;
            end
            default:
            begin
                rec_out = rec_in;
            end
        endcase
    end

endmodule
